// ===== hdl/dtvp_pkg.sv =====
// Package: shared types and constants of the two-point velocity predictor.
package dtvp_pkg;
   localparam int unsigned POS_W  = 32;
   localparam int unsigned COEF_W = 48;
   localparam int unsigned SAMP_W = 128;
   localparam int unsigned MAG_W  = 64;
   localparam int unsigned QUO_W  = 64;
   localparam int unsigned MAX_OUT = 8;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [0:0] REG_SKIP   = 1'b0;
   localparam logic [0:0] REG_ACTIVE = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [2:0]        object_index;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
      logic [POS_W-1:0]  sample_time;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_object;
      logic [COEF_W-1:0]  offset_x;
      logic [COEF_W-1:0]  velocity_x;
      logic [COEF_W-1:0]  offset_y;
      logic [COEF_W-1:0]  velocity_y;
      logic [COEF_W-1:0]  offset_z;
      logic [COEF_W-1:0]  velocity_z;
      logic [POS_W-1:0]   first_time;
      logic [POS_W-1:0]   second_time;
      logic               singular;
      logic               last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SREAD, ST_SWRITE, ST_TREAD, ST_TWAIT, ST_TLOAD, ST_MUL,
      ST_MAG, ST_DIV, ST_STORE, ST_EMIT, ST_FLUSH
   } state_type;
endpackage

// ===== hdl/dtvp_if.sv =====
// Interface: valid/ready channel carrying one word of a given type.
interface dtvp_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dtvp_ram.sv =====
// Generic single-port RAM with registered read.
module dtvp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== hdl/decimated_two_point_velocity_predictor.sv =====
// Top level: per-object two-point line fit with decimated sample capture.
//
// Use: words arrive on req (valid/ready). A pose sample word updates the
// object's decimation counter and, when it reaches skip_count, shifts the
// newer sample to older and stores the new one. A predict tick word walks
// objects 0 .. min(active_objects, OBJ_COUNT, 8)-1 and emits one rsp word
// per object holding two kept samples, last_of_run set on the final one.
// A pose sample passes a memory read, then a write back. In a
// tick, an object not fitted is read and skipped, and one with equal times
// skips the divider and gets zero coefficients. For every other fitted
// object one shared restoring divider, one quotient bit a cycle over 64
// bits, runs six times (three offsets, three velocities), each run led by
// the multiply state (two products) and the magnitude state and followed
// by the store state; the multiplier uses one 33x32 product a cycle. Each
// fitted word is held one slot so that the final one can be marked; the
// flush state at the end of the walk releases it.
// Reset clears counters, kept counts and configuration (skip 1, active 5);
// sample memories are not cleared. A stalled receiver holds the rsp word in
// its output register; the tick walk pauses until it is taken, and no new
// req word is accepted until the tick finishes.
module decimated_two_point_velocity_predictor #(
   parameter int unsigned OBJ_COUNT = 8
) (
   input  logic         clock,
   input  logic         reset,
   dtvp_if.sink         req,
   dtvp_if.source       rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:2]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import dtvp_pkg::*;

   localparam int unsigned IW = (OBJ_COUNT > 1) ? $clog2(OBJ_COUNT) : 1;
   localparam int unsigned LIM = (OBJ_COUNT < MAX_OUT) ? OBJ_COUNT : MAX_OUT;

   // configuration
   logic [7:0] skip_ff;
   logic [3:0] active_ff;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff   <= 8'd1;
         active_ff <= 4'd5;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_SKIP:   skip_ff   <= csr_pwdata[7:0];
            REG_ACTIVE: active_ff <= csr_pwdata[3:0];
            default:    ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[2])
         REG_SKIP:   csr_prdata = {24'd0, skip_ff};
         REG_ACTIVE: csr_prdata = {28'd0, active_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // per-object state: {count[7:0], kept[1:0]} and two samples
   state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   req_type       word_ff;
   logic          ctl_we, samp_we;
   logic [9:0]    ctl_wd, ctl_rd;
   logic [SAMP_W-1:0] old_rd, new_rd, new_wd;
   logic [IW-1:0] addr;

   assign addr = idx_ff;
   assign new_wd = {word_ff.pos_x, word_ff.pos_y, word_ff.pos_z, word_ff.sample_time};

   dtvp_ram #(.WIDTH(10), .DEPTH(1 << IW)) u_ctl (
      .clock(clock), .wr_en(ctl_we), .addr(addr), .wr_data(ctl_wd), .rd_data(ctl_rd));
   dtvp_ram #(.WIDTH(SAMP_W), .DEPTH(1 << IW)) u_old (
      .clock(clock), .wr_en(samp_we), .addr(addr), .wr_data(new_rd), .rd_data(old_rd));
   dtvp_ram #(.WIDTH(SAMP_W), .DEPTH(1 << IW)) u_new (
      .clock(clock), .wr_en(samp_we), .addr(addr), .wr_data(new_wd), .rd_data(new_rd));

   // clearing of the small control memory after reset is by valid bits
   logic [(1<<IW)-1:0] vld_ff;
   logic [9:0] ctl_eff;
   assign ctl_eff = vld_ff[idx_ff] ? ctl_rd : 10'd0;

   // fit datapath
   logic [POS_W-1:0]  t1_ff, t2_ff;
   logic signed [POS_W-1:0] q1_ff [3];
   logic signed [POS_W-1:0] q2_ff [3];
   logic [2:0]        ax_ff;         // coefficient 0..5: even offset, odd velocity
   logic signed [65:0] pa_ff, pb_ff; // products
   logic              neg_ff;
   logic [MAG_W-1:0]  rem_ff, num_ff;
   logic [MAG_W-1:0]  dm_ff;
   logic              dneg_ff;
   logic [6:0]        bit_ff;
   logic              mulstep_ff;
   logic [COEF_W-1:0] coef_ff [6];
   rsp_type           out_ff;
   logic              out_v_ff;

   // each fitted word waits one slot in pend_word_ff; the next fitted word
   // releases it unmarked, the end of the walk releases it as the last one
   logic       pend_ff;
   rsp_type    pend_word_ff;
   logic       out_free, emit_go, flush_go, load_out;

   assign out_free = !out_v_ff || rsp.ready;
   assign emit_go  = (state_ff == ST_EMIT) && out_free;
   assign flush_go = (state_ff == ST_FLUSH) && out_free;
   assign load_out = (emit_go && pend_ff) || flush_go;

   logic signed [32:0] dt;
   assign dt = $signed({1'b0, t2_ff}) - $signed({1'b0, t1_ff});

   logic [3:0] lim;
   assign lim = (active_ff > 4'(LIM)) ? 4'(LIM) : active_ff;

   logic last_obj;
   assign last_obj = ({1'b0, 4'(idx_ff)} + 5'd1) >= {1'b0, lim};

   // restoring divider step
   logic [MAG_W:0] trial;
   assign trial = {rem_ff, num_ff[MAG_W-1]} - {1'b0, dm_ff};

   logic [QUO_W-1:0] quo;
   assign quo = num_ff; // quotient bits shift into num as it drains
   logic [COEF_W-1:0] sat;
   always_comb begin
      if (neg_ff != dneg_ff) begin
         sat = (quo > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000
               : 48'(64'd0 - quo);
      end else begin
         sat = (quo > 64'h0000_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : quo[47:0];
      end
   end

   logic [1:0] axis;
   assign axis = 2'(ax_ff >> 1);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ctl_we   = 1'b0;
      samp_we  = 1'b0;
      ctl_wd   = ctl_eff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.data.operation == OP_SAMPLE) begin
                  idx_in = IW'(req.data.object_index);
                  state_in = (32'(req.data.object_index) < OBJ_COUNT) ? ST_SREAD : ST_IDLE;
               end else begin
                  idx_in = '0;
                  state_in = (lim == 4'd0) ? ST_IDLE : ST_TREAD;
               end
            end
         end
         ST_SREAD: state_in = ST_SWRITE;
         ST_SWRITE: begin
            ctl_we = 1'b1;
            if ((ctl_eff[9:2] + 8'd1) >= skip_ff) begin
               samp_we = 1'b1;
               ctl_wd = {8'd0, (ctl_eff[1:0] == 2'd2) ? 2'd2 : ctl_eff[1:0] + 2'd1};
            end else begin
               ctl_wd = {ctl_eff[9:2] + 8'd1, ctl_eff[1:0]};
            end
            state_in = ST_IDLE;
         end
         ST_TREAD: state_in = ST_TWAIT;
         ST_TWAIT: begin
            if (ctl_eff[1:0] == 2'd2) begin
               state_in = ST_TLOAD;
            end else if (last_obj) begin
               state_in = pend_ff ? ST_FLUSH : ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = ST_TREAD;
            end
         end
         // the time registers load at this edge, so compare the read data
         ST_TLOAD: begin
            state_in = (old_rd[POS_W-1:0] == new_rd[POS_W-1:0]) ? ST_STORE : ST_MUL;
         end
         ST_MUL:   state_in = mulstep_ff ? ST_MAG : ST_MUL;
         ST_MAG:   state_in = ST_DIV;
         ST_DIV:   state_in = (bit_ff == 7'd0) ? ST_STORE : ST_DIV;
         ST_STORE: state_in = (dt == 33'sd0 || ax_ff == 3'd5) ? ST_EMIT : ST_MUL;
         ST_EMIT: begin
            if (out_free) begin
               if (last_obj) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + IW'(1);
                  state_in = ST_TREAD;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= '0;
         out_v_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl_we) vld_ff[idx_ff] <= 1'b1;
         if (load_out) out_v_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         if (emit_go) pend_ff <= 1'b1;
         else if (flush_go) pend_ff <= 1'b0;
      end
   end

   // output word assembly (payload only)
   rsp_type cur;
   always_comb begin
      cur.out_object  = 3'(idx_ff);
      cur.offset_x    = coef_ff[0];
      cur.velocity_x  = coef_ff[1];
      cur.offset_y    = coef_ff[2];
      cur.velocity_y  = coef_ff[3];
      cur.offset_z    = coef_ff[4];
      cur.velocity_z  = coef_ff[5];
      cur.first_time  = t1_ff;
      cur.second_time = t2_ff;
      cur.singular    = (dt == 33'sd0);
      cur.last_of_run = 1'b0;
   end

   // mark the held word as last when the walk ends
   rsp_type out_in;
   always_comb begin
      out_in = pend_word_ff;
      out_in.last_of_run = (state_ff == ST_FLUSH);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) word_ff <= req.data;
      idx_ff <= idx_in;
      if (load_out) out_ff <= out_in;
      if (emit_go) pend_word_ff <= cur;
      case (state_ff)
         ST_TLOAD: begin
            {q1_ff[0], q1_ff[1], q1_ff[2], t1_ff} <= old_rd;
            {q2_ff[0], q2_ff[1], q2_ff[2], t2_ff} <= new_rd;
            ax_ff <= 3'd0;
            mulstep_ff <= 1'b0;
            for (int k = 0; k < 6; k++) coef_ff[k] <= '0;
         end
         ST_MUL: begin
            mulstep_ff <= !mulstep_ff;
            if (!mulstep_ff) begin
               pa_ff <= 66'($signed({1'b0, t2_ff}) * q1_ff[axis]);
            end else begin
               pb_ff <= 66'($signed({1'b0, t1_ff}) * q2_ff[axis]);
            end
         end
         ST_MAG: begin
            logic signed [65:0] d;
            d = ax_ff[0] ? 66'((66'(q2_ff[axis]) - 66'(q1_ff[axis])) <<< 16)
                         : pa_ff - pb_ff;
            neg_ff  <= d[65];
            num_ff  <= d[65] ? 64'(-d) : 64'(d);
            rem_ff  <= '0;
            dneg_ff <= dt[32];
            dm_ff   <= dt[32] ? 64'(-dt) : 64'(dt);
            bit_ff  <= 7'd64;
         end
         ST_DIV: begin
            if (bit_ff != 7'd0) begin
               bit_ff <= bit_ff - 7'd1;
               if (!trial[MAG_W]) begin
                  rem_ff <= trial[MAG_W-1:0];
                  num_ff <= {num_ff[MAG_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[MAG_W-2:0], num_ff[MAG_W-1]};
                  num_ff <= {num_ff[MAG_W-2:0], 1'b0};
               end
            end
         end
         ST_STORE: begin
            if (dt != 33'sd0) coef_ff[ax_ff] <= sat;
            ax_ff <= ax_ff + 3'd1;
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("rsp word changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("req accepted while busy");
   assert property (@(posedge clock) disable iff (reset)
      samp_we |-> ctl_we)
      else $error("sample write without control write");
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff != ST_IDLE)
      else $error("held word left behind at end of tick");
endmodule

// ===== verif/tb_decimated_two_point_velocity_predictor.sv =====
// Testbench: self-checking run of the two-point velocity predictor.
module tb_decimated_two_point_velocity_predictor;
   import dtvp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          OBJS      = 8;
   localparam int          WATCHDOG  = 60000;
   localparam int          SETTLE    = 600;
   localparam int          QDEPTH    = 4096;
   localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
   localparam logic [31:0] POS_MAXV  = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_MINV  = 32'h8000_0000;

   typedef struct {
      logic signed [31:0] q [3];
      logic [31:0]        t;
   } pose_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:2]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dtvp_if #(.word_type(req_type)) req_if ();
   dtvp_if #(.word_type(rsp_type)) rsp_if ();

   decimated_two_point_velocity_predictor #(.OBJ_COUNT(OBJS)) i_dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // predictor state, shadowing the block
   logic [7:0] skip_shadow   = 8'd1;
   logic [3:0] active_shadow = 4'd5;
   logic [7:0] decim_cnt [OBJS];
   logic [1:0] kept_cnt  [OBJS];
   pose_type   older_pose [OBJS];
   pose_type   newer_pose [OBJS];

   // pending words and expected fits, each read at head and filled at tail
   req_type    pending_words [QDEPTH];
   int         pend_head = 0;
   int         pend_tail = 0;
   rsp_type    expected_fits [QDEPTH];
   int         exp_head = 0;
   int         exp_tail = 0;
   logic [31:0] last_time [OBJS];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  errors = 0;
   int  words_sent = 0;
   int  fits_seen = 0;
   int  ticks_sent = 0;
   int  quiet_cycles = 0;
   bit  req_taken = 1'b0;

   // Truncating division then saturation to the signed 48-bit range.
   function automatic logic [47:0] sat_div(logic signed [66:0] num,
                                           logic signed [66:0] den);
      logic signed [66:0] quo;
      quo = num / den;
      if (quo > 67'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
      if (quo < -67'sh8000_0000_0000) return 48'h8000_0000_0000;
      return quo[47:0];
   endfunction

   function automatic rsp_type line_fit(int obj);
      rsp_type            r;
      logic signed [66:0] t1, t2, dt, q1, q2;
      logic [47:0]        c0 [3];
      logic [47:0]        c1 [3];
      t1 = $signed({35'b0, older_pose[obj].t});
      t2 = $signed({35'b0, newer_pose[obj].t});
      dt = t2 - t1;
      for (int a = 0; a < 3; a++) begin
         q1 = older_pose[obj].q[a];
         q2 = newer_pose[obj].q[a];
         if (dt == 0) begin
            c0[a] = '0;
            c1[a] = '0;
         end else begin
            c0[a] = sat_div(t2 * q1 - t1 * q2, dt);
            c1[a] = sat_div((q2 - q1) * 67'sd65536, dt);
         end
      end
      r.out_object  = obj[2:0];
      r.offset_x    = c0[0];
      r.velocity_x  = c1[0];
      r.offset_y    = c0[1];
      r.velocity_y  = c1[1];
      r.offset_z    = c0[2];
      r.velocity_z  = c1[2];
      r.first_time  = older_pose[obj].t;
      r.second_time = newer_pose[obj].t;
      r.singular    = (dt == 0);
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Advance the shadow state by one accepted word and queue its fits.
   task automatic predict_word(req_type w);
      int       lim, n;
      pose_type p;
      if (w.operation == OP_SAMPLE) begin
         decim_cnt[w.object_index] = decim_cnt[w.object_index] + 8'd1;
         if (decim_cnt[w.object_index] >= skip_shadow) begin
            p.q[0] = w.pos_x;
            p.q[1] = w.pos_y;
            p.q[2] = w.pos_z;
            p.t    = w.sample_time;
            older_pose[w.object_index] = newer_pose[w.object_index];
            newer_pose[w.object_index] = p;
            if (kept_cnt[w.object_index] < 2)
               kept_cnt[w.object_index]++;
            decim_cnt[w.object_index] = '0;
         end
      end else begin
         lim = (active_shadow > OBJS) ? OBJS : active_shadow;
         n = 0;
         for (int i = 0; i < lim; i++) begin
            if (kept_cnt[i] == 2) begin
               expected_fits[exp_tail] = line_fit(i);
               exp_tail++;
               n++;
            end
         end
         if (n > 0)
            expected_fits[exp_tail-1].last_of_run = 1'b1;
      end
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: mismatch in %s: expected %h, got %h", $time, name, exp_v,
                  act_v);
         errors++;
      end
   endtask

   // Monitor: sample both channels at the rising edge, predict and check.
   always @(posedge clock) begin
      rsp_type e, g;
      req_taken = 1'b0;
      if (!reset) begin
         req_taken = req_if.valid && req_if.ready;
         if (req_taken)
            predict_word(req_if.data);
         if (rsp_if.valid && rsp_if.ready) begin
            g = rsp_if.data;
            fits_seen++;
            if (exp_head == exp_tail) begin
               $display("%0t ns: unexpected word for object %0d", $time, g.out_object);
               errors++;
            end else begin
               e = expected_fits[exp_head];
               exp_head++;
               check_field("out_object", e.out_object, g.out_object);
               check_field("offset_x", e.offset_x, g.offset_x);
               check_field("velocity_x", e.velocity_x, g.velocity_x);
               check_field("offset_y", e.offset_y, g.offset_y);
               check_field("velocity_y", e.velocity_y, g.velocity_y);
               check_field("offset_z", e.offset_z, g.offset_z);
               check_field("velocity_z", e.velocity_z, g.velocity_z);
               check_field("first_time", e.first_time, g.first_time);
               check_field("second_time", e.second_time, g.second_time);
               check_field("singular", e.singular, g.singular);
               check_field("last_of_run", e.last_of_run, g.last_of_run);
            end
         end
         // watchdog: any handshake or config access counts as progress
         if (req_taken || (rsp_if.valid && rsp_if.ready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Driver: present the next pending word at the falling edge, idle at random, and drop rsp ready at random.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_taken) begin
            if (pend_head < pend_tail && $urandom_range(99) >= send_idle_pct) begin
               req_if.data  <= pending_words[pend_head];
               req_if.valid <= 1'b1;
               pend_head++;
               words_sent++;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // APB write: setup cycle, access cycle, then release; shadow follows.
   task automatic csr_write(logic [0:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = idx;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (idx == REG_SKIP) skip_shadow = value[7:0];
      else active_shadow = value[3:0];
   endtask

   task automatic push_pose(int obj, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] t);
      req_type w;
      w.operation    = OP_SAMPLE;
      w.object_index = obj[2:0];
      w.pos_x        = x;
      w.pos_y        = y;
      w.pos_z        = z;
      w.sample_time  = t;
      pending_words[pend_tail] = w;
      pend_tail++;
   endtask

   task automatic push_tick();
      req_type      w;
      logic [159:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      w = noise[$bits(req_type)-1:0];
      w.operation = OP_TICK;
      pending_words[pend_tail] = w;
      pend_tail++;
      ticks_sent++;
   endtask

   // Hold until every word is sent and every fit received, then let a
   // trailing tick with no fits finish before touching the registers.
   task automatic drain();
      do @(posedge clock);
      while (pend_head < pend_tail || req_if.valid || exp_head < exp_tail);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(9))
         0: return POS_MAXV;
         1: return POS_MINV;
         2, 3: return $urandom_range(2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly rising times per object, with equal, backward and wild ones mixed in.
   task automatic push_random_pose(int max_obj);
      int          obj;
      logic [31:0] t;
      obj = $urandom_range(99) < 85 ? $urandom_range(max_obj) : $urandom_range(OBJS - 1);
      case ($urandom_range(19))
         0, 1: t = last_time[obj];
         2:    t = last_time[obj] - $urandom_range(65536);
         3:    t = $urandom;
         default: t = last_time[obj] + $urandom_range(1 << 18, 1);
      endcase
      last_time[obj] = t;
      push_pose(obj, rand_pos(), rand_pos(), rand_pos(), t);
   endtask

   task automatic random_phase(int count);
      int max_obj;
      max_obj = (active_shadow == 0) ? 0 : ((active_shadow > OBJS) ? OBJS : active_shadow) - 1;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(7) == 0) push_tick();
         else push_random_pose(max_obj);
      end
      push_tick();
   endtask

   initial begin
      for (int i = 0; i < OBJS; i++) begin
         decim_cnt[i] = '0;
         kept_cnt[i]  = '0;
         last_time[i] = '0;
      end
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: tick with nothing fitted, then extremes under reset config.
      push_tick();
      push_pose(0, POS_MAXV, POS_MINV, 32'd0, 32'd0);
      push_pose(0, POS_MINV, POS_MAXV, 32'd1, TIME_MAX);
      push_pose(1, 32'd100, 32'd200, 32'd300, 32'h0001_0000);
      push_pose(1, 32'd900, 32'd800, 32'd700, 32'h0001_0000);      // equal times
      push_pose(2, 32'h0010_0000, 32'd0, POS_MINV, 32'h0005_0000);
      push_pose(2, 32'h0000_8000, POS_MAXV, 32'd5, 32'h0002_0000); // time backwards
      push_pose(3, POS_MAXV, POS_MAXV, POS_MAXV, 32'h0003_0000);   // single sample only
      push_pose(4, POS_MINV, POS_MINV, POS_MAXV, 32'd1);
      push_pose(4, POS_MAXV, POS_MAXV, POS_MINV, 32'd2);           // saturating slope
      push_pose(5, 32'd7, 32'd8, 32'd9, 32'h0000_1000);            // first of object 5
      push_pose(7, 32'd1, 32'd2, 32'd3, 32'd10);
      push_pose(7, 32'd4, 32'd5, 32'd6, 32'd20);                   // beyond active count
      push_tick();
      push_tick();
      drain();

      // Large skip: only the 40th sample of object 5 is kept, its second one.
      csr_write(REG_SKIP, 32'd40);
      csr_write(REG_ACTIVE, 32'd15);                              // clamps to all objects
      for (int k = 0; k < 40; k++)
         push_pose(5, rand_pos(), rand_pos(), rand_pos(), 32'(k * 977));
      push_tick();
      drain();

      csr_write(REG_ACTIVE, 32'd0);                               // tick yields nothing
      push_tick();
      drain();

      csr_write(REG_SKIP, 32'd0);
      csr_write(REG_ACTIVE, 32'd8);
      random_phase(50);
      drain();

      send_idle_pct = 81;
      csr_write(REG_SKIP, 32'd2);
      csr_write(REG_ACTIVE, 32'd3);
      random_phase(50);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 81;
      csr_write(REG_SKIP, 32'd1);
      csr_write(REG_ACTIVE, 32'd8);
      random_phase(60);
      drain();

      send_idle_pct  = 10;
      recv_stall_pct = 10;
      csr_write(REG_SKIP, 32'd3);
      csr_write(REG_ACTIVE, 32'd1);
      random_phase(30);
      drain();

      csr_write(REG_SKIP, 32'd1);
      csr_write(REG_ACTIVE, 32'd6);
      random_phase(30);
      drain();

      $display("Sent %0d words (%0d predict ticks), checked %0d line fits,", words_sent,
               ticks_sent, fits_seen);
      $display("over skip counts 0..40, active counts 0..15 and four idling mixes.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/dtvp_pkg.sv
hdl/dtvp_if.sv
hdl/dtvp_ram.sv
hdl/decimated_two_point_velocity_predictor.sv
verif/tb_decimated_two_point_velocity_predictor.sv
